// ===== src/vst_pkg.sv =====
// Shared types, codes and the module-letter helper function of the voice stream session tracker.
package vst_pkg;

	localparam logic [7:0] RS_ACK  = 8'h72;
	localparam logic [7:0] RS_SEND = 8'h73;

	localparam logic [15:0] LEN_START    = 16'd48;
	localparam logic [15:0] LEN_NORMAL   = 16'd19;
	localparam logic [15:0] LEN_EXTENDED = 16'd22;

	localparam logic [4:0] SEQ_MAX     = 5'd20;
	localparam int         SEQ_END_BIT = 6;

	localparam logic [7:0] CHAR_A_UPPER = 8'h41;
	localparam logic [7:0] CHAR_B_UPPER = 8'h42;
	localparam logic [7:0] CHAR_C_UPPER = 8'h43;
	localparam logic [7:0] CHAR_A_LOWER = 8'h61;
	localparam logic [7:0] CHAR_B_LOWER = 8'h62;
	localparam logic [7:0] CHAR_C_LOWER = 8'h63;

	localparam int MAX_MODULES = 3;

	typedef enum logic [2:0] {
		CFG_MY_ADDRESS   = 3'd0,
		CFG_MODULE_EN    = 3'd1,
		CFG_BASE_PORT    = 3'd2,
		CFG_PORT_STEP    = 3'd3,
		CFG_VOICE_TYPE   = 3'd4,
		CFG_TIMEOUT_ARM  = 3'd5
	} cfg_index_t;

	typedef enum logic [3:0] {
		DROP_NONE       = 4'd0,
		DROP_NOT_UDP    = 4'd1,
		DROP_NOT_MINE   = 4'd2,
		DROP_BAD_SIG    = 4'd3,
		DROP_ACK        = 4'd4,
		DROP_NOT_SEND   = 4'd5,
		DROP_NOT_VOICE  = 4'd6,
		DROP_BAD_LEN    = 4'd7,
		DROP_BAD_MODULE = 4'd8,
		DROP_DISABLED   = 4'd9,
		DROP_BUSY       = 4'd10,
		DROP_UNKNOWN    = 4'd11,
		DROP_WRONG_DIR  = 4'd12,
		DROP_BAD_SEQ    = 4'd13,
		DROP_TICK       = 4'd14
	} drop_reason_t;

	typedef enum logic [1:0] {
		KIND_START    = 2'd0,
		KIND_NORMAL   = 2'd1,
		KIND_EXTENDED = 2'd2
	} frame_kind_t;

	typedef struct packed {
		logic        mode;
		logic        is_udp;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic        signature_ok;
		logic [7:0]  rs_flag;
		logic [7:0]  packet_type;
		logic [15:0] data_len;
		logic [7:0]  rpt1_module;
		logic [7:0]  rpt2_module;
		logic [15:0] stream_id;
		logic [7:0]  seq_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] my_address;
		logic [2:0]  module_enable;
		logic [15:0] base_port;
		logic [15:0] port_step;
		logic [7:0]  voice_type_code;
		logic [1:0]  timeout_arm;
	} cfg_t;

	// Verdict on one request, handed from the checker to the session table.
	typedef struct packed {
		logic         forward;
		drop_reason_t reason;
		logic [1:0]   module_idx;
		frame_kind_t  kind;
		logic         outbound;
		logic         ended;
		logic         start;
	} dec_t;

	typedef struct packed {
		logic         forward;
		drop_reason_t drop_reason;
		logic [1:0]   module_res;
		frame_kind_t  frame_kind;
		logic         outbound;
		logic [15:0]  out_sequence;
		logic [15:0]  dest_port;
		logic         session_ended;
		logic [2:0]   expired_mask;
	} result_t;

	// Returns {valid, index} for a module letter in either case.
	function automatic logic [2:0] decode_module(input logic [7:0] c);
		logic [2:0] r;
		r = 3'b000;
		if (c == CHAR_A_UPPER || c == CHAR_A_LOWER) r = 3'b100;
		if (c == CHAR_B_UPPER || c == CHAR_B_LOWER) r = 3'b101;
		if (c == CHAR_C_UPPER || c == CHAR_C_LOWER) r = 3'b110;
		return r;
	endfunction

endpackage

// ===== src/vst_item_if.sv =====
// Request channel carrying one packet header or one tick.
interface vst_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic        is_udp;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic        signature_ok;
	logic [7:0]  rs_flag;
	logic [7:0]  packet_type;
	logic [15:0] data_len;
	logic [7:0]  rpt1_module;
	logic [7:0]  rpt2_module;
	logic [15:0] stream_id;
	logic [7:0]  seq_byte;

	modport source (
		output valid, mode, is_udp, src_addr, dst_addr, signature_ok, rs_flag,
		       packet_type, data_len, rpt1_module, rpt2_module, stream_id, seq_byte,
		input  ready
	);
	modport sink (
		input  valid, mode, is_udp, src_addr, dst_addr, signature_ok, rs_flag,
		       packet_type, data_len, rpt1_module, rpt2_module, stream_id, seq_byte,
		output ready
	);
endinterface

// ===== src/vst_result_if.sv =====
// Result channel carrying the verdict for one request.
interface vst_result_if;
	logic        valid;
	logic        ready;
	logic        forward;
	logic [3:0]  drop_reason;
	logic [1:0]  module_res;
	logic [1:0]  frame_kind;
	logic        outbound;
	logic [15:0] out_sequence;
	logic [15:0] dest_port;
	logic        session_ended;
	logic [2:0]  expired_mask;

	modport source (
		output valid, forward, drop_reason, module_res, frame_kind, outbound,
		       out_sequence, dest_port, session_ended, expired_mask,
		input  ready
	);
	modport sink (
		input  valid, forward, drop_reason, module_res, frame_kind, outbound,
		       out_sequence, dest_port, session_ended, expired_mask,
		output ready
	);
endinterface

// ===== src/vst_check.sv =====
// Packet filter chain and session lookup producing the verdict for one request.
module vst_check #(
	parameter int MODULES = 3
) (
	input  vst_pkg::item_t      item,
	input  vst_pkg::cfg_t       cfg,
	input  logic [MODULES-1:0]  active,
	input  logic [MODULES-1:0]  outbound,
	input  logic [MODULES-1:0]  timed,
	input  logic [15:0]         stream [MODULES],
	output vst_pkg::dec_t       dec,
	output logic [MODULES-1:0]  sel
);

	localparam logic [2:0] MOD_N = 3'(MODULES);

	logic               dir_out;
	logic               dir_in;
	logic               dir;
	logic [2:0]         ch_dec;
	logic               ch_ok;
	logic [1:0]         ch_idx;
	logic [MODULES-1:0] en;
	logic [MODULES-1:0] start_sel;
	logic [MODULES-1:0] hit;
	logic [MODULES-1:0] data_sel;
	logic [1:0]         data_idx;
	logic               taken;
	logic               len_ok;

	assign dir_out = (item.src_addr == cfg.my_address);
	assign dir_in  = (item.dst_addr == cfg.my_address);
	assign dir     = dir_out;
	assign ch_dec  = vst_pkg::decode_module(dir_out ? item.rpt2_module : item.rpt1_module);
	assign ch_ok   = ch_dec[2];
	assign ch_idx  = ch_dec[1:0];
	assign en      = cfg.module_enable[MODULES-1:0];
	assign len_ok  = (item.data_len == vst_pkg::LEN_START) ||
	                 (item.data_len == vst_pkg::LEN_NORMAL) ||
	                 (item.data_len == vst_pkg::LEN_EXTENDED);

	// The lowest enabled module with a matching stored id wins, active or not.
	always_comb begin
		taken    = 1'b0;
		data_idx = 2'd0;
		for (int i = 0; i < MODULES; i++) begin
			start_sel[i] = ch_ok && (ch_idx == 2'(i));
			hit[i]       = en[i] && (stream[i] == item.stream_id);
			data_sel[i]  = hit[i] && !taken;
			if (data_sel[i]) begin
				data_idx = 2'(i);
			end
			taken = taken | hit[i];
		end
	end

	always_comb begin
		dec        = '0;
		dec.reason = vst_pkg::DROP_NONE;
		dec.kind   = vst_pkg::KIND_START;
		sel        = '0;
		if (item.mode) begin
			dec.reason = vst_pkg::DROP_TICK;
		end else if (!item.is_udp) begin
			dec.reason = vst_pkg::DROP_NOT_UDP;
		end else if (!(dir_out || dir_in)) begin
			dec.reason = vst_pkg::DROP_NOT_MINE;
		end else if (!item.signature_ok) begin
			dec.reason = vst_pkg::DROP_BAD_SIG;
		end else if (item.rs_flag == vst_pkg::RS_ACK) begin
			dec.reason = vst_pkg::DROP_ACK;
		end else if (item.rs_flag != vst_pkg::RS_SEND) begin
			dec.reason = vst_pkg::DROP_NOT_SEND;
		end else if (item.packet_type != cfg.voice_type_code) begin
			dec.reason = vst_pkg::DROP_NOT_VOICE;
		end else if (!len_ok) begin
			dec.reason = vst_pkg::DROP_BAD_LEN;
		end else if (item.data_len == vst_pkg::LEN_START) begin
			if (!ch_ok || ({1'b0, ch_idx} >= MOD_N)) begin
				dec.reason = vst_pkg::DROP_BAD_MODULE;
			end else if (!(|(start_sel & en))) begin
				dec.reason = vst_pkg::DROP_DISABLED;
			end else if (|(start_sel & active & timed)) begin
				dec.reason = vst_pkg::DROP_BUSY;
			end else begin
				dec.forward    = 1'b1;
				dec.start      = 1'b1;
				dec.module_idx = ch_idx;
				dec.kind       = vst_pkg::KIND_START;
				dec.outbound   = dir;
				sel            = start_sel;
			end
		end else begin
			if (!taken) begin
				dec.reason = vst_pkg::DROP_UNKNOWN;
			end else if ((|(data_sel & outbound)) != dir) begin
				dec.reason = vst_pkg::DROP_WRONG_DIR;
			end else if (item.seq_byte[4:0] > vst_pkg::SEQ_MAX) begin
				dec.reason = vst_pkg::DROP_BAD_SEQ;
			end else begin
				dec.forward    = 1'b1;
				dec.module_idx = data_idx;
				dec.kind       = (item.data_len == vst_pkg::LEN_NORMAL) ?
				                 vst_pkg::KIND_NORMAL : vst_pkg::KIND_EXTENDED;
				dec.outbound   = dir;
				dec.ended      = item.seq_byte[vst_pkg::SEQ_END_BIT];
				sel            = data_sel;
			end
		end
	end

endmodule

// ===== src/voice_stream_session_tracker_core.sv =====
// Top level of the voice stream session tracker: input register, session table, result register.
//
// Each request is a packet header or a one-second tick. It is captured in an input register,
// judged in one pass against the per-module session table (all modules compared in parallel),
// and its verdict is registered in the result register once that register is empty or its
// result is being taken; it leaves from there. One request is taken every cycle while results are being
// drained. While a finished result waits, the input register can still take one more request;
// after that the input stalls until the result leaves. The session table and sequence counter
// update in the same cycle the verdict is registered, so back-to-back requests see each
// other's effects in order. Configuration registers reset to their documented values.
module voice_stream_session_tracker_core #(
	parameter int MODULES = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	vst_item_if.sink           pkt,
	vst_result_if.source       res,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	vst_pkg::cfg_t      cfg_q;
	vst_pkg::item_t     item_in;
	vst_pkg::item_t     item_s1;
	logic               valid_s1;
	logic               advance;
	vst_pkg::dec_t      dec;
	logic [MODULES-1:0] sel;
	vst_pkg::result_t   result;
	vst_pkg::result_t   res_q;
	logic               res_valid_q;

	logic [MODULES-1:0] active_q;
	logic [MODULES-1:0] outbound_q;
	logic [15:0]        stream_q  [MODULES];
	logic [1:0]         timeout_q [MODULES];
	logic [MODULES-1:0] timed;
	logic [15:0]        counter_q;
	logic [2:0]         expired;
	logic [15:0]        port;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.my_address      <= 32'hAC10_0014;
			cfg_q.module_enable   <= 3'd1;
			cfg_q.base_port       <= 16'd4200;
			cfg_q.port_step       <= 16'd1;
			cfg_q.voice_type_code <= 8'd18;
			cfg_q.timeout_arm     <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				vst_pkg::CFG_MY_ADDRESS:  cfg_q.my_address      <= cfg_data;
				vst_pkg::CFG_MODULE_EN:   cfg_q.module_enable   <= cfg_data[2:0];
				vst_pkg::CFG_BASE_PORT:   cfg_q.base_port       <= cfg_data[15:0];
				vst_pkg::CFG_PORT_STEP:   cfg_q.port_step       <= cfg_data[15:0];
				vst_pkg::CFG_VOICE_TYPE:  cfg_q.voice_type_code <= cfg_data[7:0];
				vst_pkg::CFG_TIMEOUT_ARM: cfg_q.timeout_arm     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Input register
	assign item_in = '{
		mode:         pkt.mode,
		is_udp:       pkt.is_udp,
		src_addr:     pkt.src_addr,
		dst_addr:     pkt.dst_addr,
		signature_ok: pkt.signature_ok,
		rs_flag:      pkt.rs_flag,
		packet_type:  pkt.packet_type,
		data_len:     pkt.data_len,
		rpt1_module:  pkt.rpt1_module,
		rpt2_module:  pkt.rpt2_module,
		stream_id:    pkt.stream_id,
		seq_byte:     pkt.seq_byte
	};

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			item_s1 <= item_in;
		end
	end

	// Verdict
	always_comb begin
		for (int i = 0; i < MODULES; i++) begin
			timed[i] = (timeout_q[i] != 2'd0);
		end
	end

	vst_check #(
		.MODULES (MODULES)
	) u_check (
		.item     (item_s1),
		.cfg      (cfg_q),
		.active   (active_q),
		.outbound (outbound_q),
		.timed    (timed),
		.stream   (stream_q),
		.dec      (dec),
		.sel      (sel)
	);

	// A tick reports the modules whose timeout is about to step from one to zero.
	always_comb begin
		expired = '0;
		for (int i = 0; i < MODULES; i++) begin
			expired[i] = item_s1.mode && (timeout_q[i] == 2'd1);
		end
	end

	assign port = cfg_q.base_port +
	              (dec.module_idx[0] ? cfg_q.port_step : 16'd0) +
	              (dec.module_idx[1] ? {cfg_q.port_step[14:0], 1'b0} : 16'd0);

	always_comb begin
		result               = '0;
		result.forward       = dec.forward;
		result.drop_reason   = dec.reason;
		result.module_res    = dec.module_idx;
		result.frame_kind    = dec.kind;
		result.outbound      = dec.outbound;
		result.session_ended = dec.ended;
		result.expired_mask  = expired;
		if (dec.forward) begin
			result.out_sequence = counter_q;
			result.dest_port    = port;
		end
	end

	// Session table and sequence counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			outbound_q <= '0;
			counter_q  <= '0;
			for (int i = 0; i < MODULES; i++) begin
				stream_q[i]  <= '0;
				timeout_q[i] <= '0;
			end
		end else if (advance) begin
			if (item_s1.mode) begin
				for (int i = 0; i < MODULES; i++) begin
					if (timeout_q[i] != 2'd0) begin
						timeout_q[i] <= timeout_q[i] - 2'd1;
					end
				end
			end else if (dec.forward) begin
				counter_q <= counter_q + 16'd1;
				for (int i = 0; i < MODULES; i++) begin
					if (sel[i]) begin
						timeout_q[i] <= cfg_q.timeout_arm;
						if (dec.start) begin
							stream_q[i]   <= item_s1.stream_id;
							outbound_q[i] <= dec.outbound;
							active_q[i]   <= 1'b1;
						end else if (dec.ended) begin
							active_q[i] <= 1'b0;
						end
					end
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.forward       = res_q.forward;
	assign res.drop_reason   = res_q.drop_reason;
	assign res.module_res    = res_q.module_res;
	assign res.frame_kind    = res_q.frame_kind;
	assign res.outbound      = res_q.outbound;
	assign res.out_sequence  = res_q.out_sequence;
	assign res.dest_port     = res_q.dest_port;
	assign res.session_ended = res_q.session_ended;
	assign res.expired_mask  = res_q.expired_mask;

	// Assertions
	a_one_module: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(sel))
		else $error("more than one module selected for a request");

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && dec.forward |=> counter_q == $past(counter_q) + 16'd1)
		else $error("sequence counter did not advance on a forwarded packet");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.forward |->
			res.out_sequence == 16'd0 && res.dest_port == 16'd0 && res.session_ended == 1'b0)
		else $error("dropped result carries nonzero fields");

	a_tick_only_mask: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.expired_mask != 3'd0 |->
			res.drop_reason == vst_pkg::DROP_TICK)
		else $error("expired mask set on a packet result");

endmodule

// ===== verif/voice_stream_session_tracker_core_tb.sv =====
// Self-checking testbench for the voice stream session tracker: filters, sessions and flow control.
module voice_stream_session_tracker_core_tb;

	localparam int TRACKED     = 3;
	localparam int MAX_GAP     = 12;
	localparam int LONG_HOLD   = 80;
	localparam int STALL_LIMIT = 1000;
	localparam int REPORT_MAX  = 10;
	localparam vst_pkg::cfg_t RESET_SETTINGS = '{
		my_address: 32'hAC10_0014, module_enable: 3'b001, base_port: 16'd4200,
		port_step: 16'd1, voice_type_code: 8'd18, timeout_arm: 2'd3
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	vst_item_if   req_ch ();
	vst_result_if verdict_ch ();

	voice_stream_session_tracker_core #(.MODULES(TRACKED)) DUT (
		.clk(clk), .arst_n(arst_n), .pkt(req_ch), .res(verdict_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Session table and settings as the block should hold them.
	vst_pkg::cfg_t    live_cfg;
	logic             sess_active   [TRACKED];
	logic             sess_outbound [TRACKED];
	logic [15:0]      sess_stream   [TRACKED];
	logic [1:0]       sess_timeout  [TRACKED];
	logic [15:0]      seq_count;
	vst_pkg::result_t verdicts [$];
	vst_pkg::result_t oldest;

	bit        no_idle;
	int        hold_off;
	int        dead_cycles;
	int        mismatches;
	int        n_requests;
	int        n_forwarded;
	int        n_ticks;
	int        n_settings;
	bit [14:0] codes_seen;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic vst_pkg::result_t judge_request(input vst_pkg::item_t r);
		vst_pkg::result_t      v;
		vst_pkg::drop_reason_t why;
		logic                  outb;
		logic [7:0]            letter;
		logic [15:0]           port;
		int                    m;
		int                    i;
		v   = '0;
		why = vst_pkg::DROP_NONE;
		m   = -1;
		if (r.mode) begin
			v.drop_reason = vst_pkg::DROP_TICK;
			for (i = 0; i < TRACKED; i++) begin
				if (sess_timeout[i] != 2'd0) begin
					sess_timeout[i] = sess_timeout[i] - 2'd1;
					v.expired_mask[i] = (sess_timeout[i] == 2'd0);
				end
			end
			return v;
		end
		// A packet from my own address counts as outbound even when it is also addressed to me.
		outb = (r.src_addr == live_cfg.my_address);
		if (!r.is_udp)
			why = vst_pkg::DROP_NOT_UDP;
		else if (!outb && r.dst_addr != live_cfg.my_address)
			why = vst_pkg::DROP_NOT_MINE;
		else if (!r.signature_ok)
			why = vst_pkg::DROP_BAD_SIG;
		else if (r.rs_flag == vst_pkg::RS_ACK)
			why = vst_pkg::DROP_ACK;
		else if (r.rs_flag != vst_pkg::RS_SEND)
			why = vst_pkg::DROP_NOT_SEND;
		else if (r.packet_type != live_cfg.voice_type_code)
			why = vst_pkg::DROP_NOT_VOICE;
		else if (r.data_len != vst_pkg::LEN_START && r.data_len != vst_pkg::LEN_NORMAL
				&& r.data_len != vst_pkg::LEN_EXTENDED)
			why = vst_pkg::DROP_BAD_LEN;
		else if (r.data_len == vst_pkg::LEN_START) begin
			letter = outb ? r.rpt2_module : r.rpt1_module;
			case (letter)
				vst_pkg::CHAR_A_UPPER, vst_pkg::CHAR_A_LOWER: m = 0;
				vst_pkg::CHAR_B_UPPER, vst_pkg::CHAR_B_LOWER: m = 1;
				vst_pkg::CHAR_C_UPPER, vst_pkg::CHAR_C_LOWER: m = 2;
				default:                                      m = -1;
			endcase
			if (m < 0 || m >= TRACKED)
				why = vst_pkg::DROP_BAD_MODULE;
			else if (!live_cfg.module_enable[m])
				why = vst_pkg::DROP_DISABLED;
			else if (sess_active[m] && sess_timeout[m] != 2'd0)
				why = vst_pkg::DROP_BUSY;
			else begin
				sess_stream[m]   = r.stream_id;
				sess_outbound[m] = outb;
				sess_active[m]   = 1'b1;
				v.frame_kind     = vst_pkg::KIND_START;
			end
		end else begin
			// The stored id decides, whether or not that session is still active.
			for (i = 0; i < TRACKED; i++) begin
				if (m < 0 && live_cfg.module_enable[i] && sess_stream[i] == r.stream_id)
					m = i;
			end
			if (m < 0)
				why = vst_pkg::DROP_UNKNOWN;
			else if (outb != sess_outbound[m])
				why = vst_pkg::DROP_WRONG_DIR;
			else if (r.seq_byte[4:0] > vst_pkg::SEQ_MAX)
				why = vst_pkg::DROP_BAD_SEQ;
			else begin
				if (r.seq_byte[vst_pkg::SEQ_END_BIT]) begin
					sess_active[m]  = 1'b0;
					v.session_ended = 1'b1;
				end
				v.frame_kind = (r.data_len == vst_pkg::LEN_NORMAL) ?
						vst_pkg::KIND_NORMAL : vst_pkg::KIND_EXTENDED;
			end
		end
		if (why != vst_pkg::DROP_NONE) begin
			v = '0;
			v.drop_reason = why;
			return v;
		end
		port = live_cfg.base_port + 16'(m) * live_cfg.port_step;
		v.forward      = 1'b1;
		v.drop_reason  = vst_pkg::DROP_NONE;
		v.module_res   = 2'(m);
		v.outbound     = outb;
		v.out_sequence = seq_count;
		v.dest_port    = port;
		seq_count       = seq_count + 16'd1;
		sess_timeout[m] = live_cfg.timeout_arm;
		return v;
	endfunction

	function automatic logic [31:0] other_address();
		logic [31:0] a;
		do a = $urandom; while (a == live_cfg.my_address);
		return a;
	endfunction

	function automatic vst_pkg::item_t random_item();
		vst_pkg::item_t it;
		it.mode         = 1'($urandom);
		it.is_udp       = 1'($urandom);
		it.src_addr     = $urandom;
		it.dst_addr     = $urandom;
		it.signature_ok = 1'($urandom);
		it.rs_flag      = 8'($urandom);
		it.packet_type  = 8'($urandom);
		it.data_len     = 16'($urandom);
		it.rpt1_module  = 8'($urandom);
		it.rpt2_module  = 8'($urandom);
		it.stream_id    = 16'($urandom);
		it.seq_byte     = 8'($urandom);
		return it;
	endfunction

	function automatic vst_pkg::item_t tick_item();
		vst_pkg::item_t it;
		it = random_item();
		it.mode = 1'b1;
		return it;
	endfunction

	// A packet that passes the header filters through the length check; the unused module character stays random.
	function automatic vst_pkg::item_t voice_packet(input logic outb, input logic [15:0] len,
			input int k, input logic [15:0] sid, input logic [7:0] seq);
		vst_pkg::item_t it;
		logic [7:0]     letter;
		it = random_item();
		case (k)
			0:       letter = $urandom_range(0, 1) ? vst_pkg::CHAR_A_UPPER : vst_pkg::CHAR_A_LOWER;
			1:       letter = $urandom_range(0, 1) ? vst_pkg::CHAR_B_UPPER : vst_pkg::CHAR_B_LOWER;
			default: letter = $urandom_range(0, 1) ? vst_pkg::CHAR_C_UPPER : vst_pkg::CHAR_C_LOWER;
		endcase
		it.mode         = 1'b0;
		it.is_udp       = 1'b1;
		it.signature_ok = 1'b1;
		it.rs_flag      = vst_pkg::RS_SEND;
		it.packet_type  = live_cfg.voice_type_code;
		it.data_len     = len;
		it.stream_id    = sid;
		it.seq_byte     = seq;
		if (outb) begin
			it.src_addr    = live_cfg.my_address;
			it.rpt2_module = letter;
		end else begin
			it.src_addr    = other_address();
			it.dst_addr    = live_cfg.my_address;
			it.rpt1_module = letter;
		end
		return it;
	endfunction

	function automatic vst_pkg::item_t break_filter(input vst_pkg::item_t it,
			input vst_pkg::drop_reason_t stage);
		logic [7:0] c;
		case (stage)
			vst_pkg::DROP_NOT_UDP:   it.is_udp = 1'b0;
			vst_pkg::DROP_NOT_MINE: begin
				it.src_addr = other_address();
				it.dst_addr = other_address();
			end
			vst_pkg::DROP_BAD_SIG:   it.signature_ok = 1'b0;
			vst_pkg::DROP_ACK:       it.rs_flag = vst_pkg::RS_ACK;
			vst_pkg::DROP_NOT_SEND:
				do it.rs_flag = 8'($urandom);
				while (it.rs_flag == vst_pkg::RS_ACK || it.rs_flag == vst_pkg::RS_SEND);
			vst_pkg::DROP_NOT_VOICE:
				do it.packet_type = 8'($urandom);
				while (it.packet_type == live_cfg.voice_type_code);
			vst_pkg::DROP_BAD_LEN:
				do it.data_len = $urandom_range(0, 1) ? 16'($urandom)
						: 16'($urandom_range(0, 63));
				while (it.data_len == vst_pkg::LEN_START || it.data_len == vst_pkg::LEN_NORMAL
						|| it.data_len == vst_pkg::LEN_EXTENDED);
			vst_pkg::DROP_BAD_MODULE: begin
				// Pushing a module letter into the upper half of the byte makes it invalid.
				c = 8'($urandom);
				if ((c | 8'h20) >= vst_pkg::CHAR_A_LOWER && (c | 8'h20) <= vst_pkg::CHAR_C_LOWER)
					c[7] = 1'b1;
				it.rpt1_module = c;
				it.rpt2_module = c;
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic put_fields(input vst_pkg::item_t it);
		req_ch.mode         <= it.mode;
		req_ch.is_udp       <= it.is_udp;
		req_ch.src_addr     <= it.src_addr;
		req_ch.dst_addr     <= it.dst_addr;
		req_ch.signature_ok <= it.signature_ok;
		req_ch.rs_flag      <= it.rs_flag;
		req_ch.packet_type  <= it.packet_type;
		req_ch.data_len     <= it.data_len;
		req_ch.rpt1_module  <= it.rpt1_module;
		req_ch.rpt2_module  <= it.rpt2_module;
		req_ch.stream_id    <= it.stream_id;
		req_ch.seq_byte     <= it.seq_byte;
	endtask

	// Valid stays high after a request is taken; the next call either lowers it or replaces
	// the payload in the same time step.
	task automatic send_item(input vst_pkg::item_t it);
		vst_pkg::result_t v;
		int               gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		put_fields(it);
		do @(posedge clk); while (!req_ch.ready);
		v = judge_request(it);
		verdicts.push_back(v);
		n_requests++;
		if (it.mode)
			n_ticks++;
		if (v.forward)
			n_forwarded++;
		codes_seen[v.drop_reason] = 1'b1;
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input vst_pkg::cfg_t c);
		cfg_we    <= 1'b1;
		cfg_index <= vst_pkg::CFG_MY_ADDRESS;
		cfg_data  <= c.my_address;
		@(posedge clk);
		cfg_index <= vst_pkg::CFG_MODULE_EN;
		cfg_data  <= 32'(c.module_enable);
		@(posedge clk);
		cfg_index <= vst_pkg::CFG_BASE_PORT;
		cfg_data  <= 32'(c.base_port);
		@(posedge clk);
		cfg_index <= vst_pkg::CFG_PORT_STEP;
		cfg_data  <= 32'(c.port_step);
		@(posedge clk);
		cfg_index <= vst_pkg::CFG_VOICE_TYPE;
		cfg_data  <= 32'(c.voice_type_code);
		@(posedge clk);
		cfg_index <= vst_pkg::CFG_TIMEOUT_ARM;
		cfg_data  <= 32'(c.timeout_arm);
		@(posedge clk);
		cfg_we <= 1'b0;
		live_cfg = c;
		n_settings++;
	endtask

	// Mostly coherent session traffic built on the expected table, plus ticks, noise and
	// packets broken at one filter stage.
	task automatic run_traffic(input int count);
		vst_pkg::item_t it;
		int             pick;
		int             k;
		logic           outb;
		logic [7:0]     seq;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			k    = $urandom_range(0, TRACKED - 1);
			if (pick < 10)
				it = tick_item();
			else if (pick < 18)
				it = random_item();
			else if (!sess_active[k] || $urandom_range(0, 9) == 0)
				it = voice_packet(1'($urandom), vst_pkg::LEN_START, k, 16'($urandom),
						8'($urandom));
			else begin
				outb = sess_outbound[k] ^ ($urandom_range(0, 9) == 0);
				seq  = {1'($urandom), $urandom_range(0, 7) == 0, 1'($urandom),
						5'($urandom_range(0, 20))};
				if ($urandom_range(0, 9) == 0)
					seq[4:0] = 5'($urandom_range(21, 31));
				it = voice_packet(outb, $urandom_range(0, 1) ? vst_pkg::LEN_NORMAL
						: vst_pkg::LEN_EXTENDED, k,
						($urandom_range(0, 14) == 0) ? 16'($urandom) : sess_stream[k], seq);
			end
			if (pick >= 18 && pick < 32)
				it = break_filter(it, vst_pkg::drop_reason_t'(4'($urandom_range(
						vst_pkg::DROP_NOT_UDP, vst_pkg::DROP_BAD_MODULE))));
			send_item(it);
		end
	endtask

	task automatic test_filters_and_sessions();
		vst_pkg::item_t it;
		int             s;
		send_item(tick_item());
		for (s = int'(vst_pkg::DROP_NOT_UDP); s <= int'(vst_pkg::DROP_BAD_LEN); s++)
			send_item(break_filter(voice_packet(1'b0, vst_pkg::LEN_START, 0, 16'h1234, 8'h00),
					vst_pkg::drop_reason_t'(s[3:0])));
		// Every stored stream id is zero after reset, so stream zero already finds module A.
		send_item(voice_packet(1'b0, vst_pkg::LEN_NORMAL, 0, 16'h0000, 8'h00));
		send_item(voice_packet(1'b0, vst_pkg::LEN_START, 0, 16'hFFFF, 8'hFF));
		send_item(voice_packet(1'b0, vst_pkg::LEN_START, 0, 16'h0042, 8'h00));
		send_item(voice_packet(1'b1, vst_pkg::LEN_START, 1, 16'h0042, 8'h00));
		send_item(break_filter(voice_packet(1'b1, vst_pkg::LEN_START, 2, 16'h0042, 8'h00),
				vst_pkg::DROP_BAD_MODULE));
		it = voice_packet(1'b1, vst_pkg::LEN_NORMAL, 0, 16'hFFFF, 8'h00);
		it.dst_addr = live_cfg.my_address;
		send_item(it);
		send_item(voice_packet(1'b0, vst_pkg::LEN_NORMAL, 0, 16'hFFFF, 8'h15));
		send_item(voice_packet(1'b0, vst_pkg::LEN_EXTENDED, 0, 16'hFFFF, 8'hB4));
		send_item(voice_packet(1'b0, vst_pkg::LEN_NORMAL, 0, 16'h0001, 8'h00));
		repeat (3) send_item(tick_item());
		// The session on A has timed out, so a new start may claim it in the other direction.
		send_item(voice_packet(1'b1, vst_pkg::LEN_START, 0, 16'h00FF, 8'h00));
		send_item(voice_packet(1'b1, vst_pkg::LEN_NORMAL, 0, 16'h00FF, 8'h5F));
		send_item(voice_packet(1'b1, vst_pkg::LEN_NORMAL, 0, 16'h00FF, 8'h54));
		send_item(voice_packet(1'b0, vst_pkg::LEN_START, 0, 16'h7FFF, 8'h00));
	endtask

	task automatic test_register_settings();
		settle();
		apply_settings(vst_pkg::cfg_t'{32'hFFFF_FFFF, 3'b111, 16'hFFFF, 16'hFFFF, 8'hFF,
				2'd0});
		run_traffic(150);
		settle();
		apply_settings(vst_pkg::cfg_t'{32'h0000_0000, 3'b110, 16'h0000, 16'h0000, 8'h00,
				2'd1});
		run_traffic(150);
		settle();
		apply_settings(vst_pkg::cfg_t'{32'($urandom), 3'b000, 16'($urandom), 16'($urandom),
				8'($urandom), 2'd2});
		run_traffic(100);
		settle();
		apply_settings(vst_pkg::cfg_t'{32'($urandom), 3'b101, 16'($urandom), 16'($urandom),
				8'($urandom), 2'd3});
		run_traffic(150);
	endtask

	task automatic test_busy_traffic();
		settle();
		apply_settings(vst_pkg::cfg_t'{32'($urandom), 3'b111, 16'($urandom), 16'($urandom),
				8'($urandom), 2'd3});
		run_traffic(550);
	endtask

	// Back-to-back requests against a long output hold-off fill the block and stall its input.
	task automatic test_output_backpressure();
		no_idle  = 1'b1;
		hold_off = LONG_HOLD;
		run_traffic(60);
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause();
		run_traffic(80);
		settle();
		run_traffic(80);
	endtask

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			report($sformatf("%s expected %0h, got %0h", name, want, got));
	endtask

	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			if (verdicts.size() == 0)
				report("result arrived with no request pending");
			else begin
				oldest = verdicts.pop_front();
				check_field("forward", 32'(oldest.forward), 32'(verdict_ch.forward));
				check_field("drop_reason", 32'(oldest.drop_reason), 32'(verdict_ch.drop_reason));
				check_field("module_res", 32'(oldest.module_res), 32'(verdict_ch.module_res));
				check_field("frame_kind", 32'(oldest.frame_kind), 32'(verdict_ch.frame_kind));
				check_field("outbound", 32'(oldest.outbound), 32'(verdict_ch.outbound));
				check_field("out_sequence", 32'(oldest.out_sequence),
						32'(verdict_ch.out_sequence));
				check_field("dest_port", 32'(oldest.dest_port), 32'(verdict_ch.dest_port));
				check_field("session_ended", 32'(oldest.session_ended),
						32'(verdict_ch.session_ended));
				check_field("expired_mask", 32'(oldest.expired_mask),
						32'(verdict_ch.expired_mask));
			end
		end
	end

	// Output side: a random stall before each result, and the long hold-off when asked.
	initial begin
		int pause;
		verdict_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off > 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			pause = draw_gap();
			if (pause > 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			verdict_ch.ready <= 1'b1;
			do @(posedge clk); while (!verdict_ch.valid);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
			dead_cycles = 0;
		else
			dead_cycles++;
		if (dead_cycles >= STALL_LIMIT) begin
			$display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
			$display("voice_stream_session_tracker_core_tb: errors");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n       = 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= vst_pkg::CFG_MY_ADDRESS;
		cfg_data     <= '0;
		req_ch.valid <= 1'b0;
		put_fields('0);
		live_cfg  = RESET_SETTINGS;
		seq_count = '0;
		for (i = 0; i < TRACKED; i++) begin
			sess_active[i]   = 1'b0;
			sess_outbound[i] = 1'b0;
			sess_stream[i]   = '0;
			sess_timeout[i]  = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_filters_and_sessions();
		test_register_settings();
		test_busy_traffic();
		test_output_backpressure();
		test_drain_pause();

		settle();
		repeat (8) @(posedge clk);
		$display("Ran %0d requests (%0d forwarded, %0d ticks) under %0d register settings.",
				n_requests, n_forwarded, n_ticks, n_settings);
		$display("Saw %0d of 15 verdict codes; output held off once for %0d cycles.",
				$countones(codes_seen), LONG_HOLD);
		if (mismatches == 0)
			$display("voice_stream_session_tracker_core_tb: clean");
		else
			$display("voice_stream_session_tracker_core_tb: errors");
		$finish;
	end

endmodule
